[rtl/core/hng_pkg.sv]
// Shared types for the Hamming number generator.
// Holds the control-state enum and the pointer-advance flag group.
// No dependencies.
package hng_pkg;

    // Width of the requested position
    localparam int POS_W = 12;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_FETCH,
        S_DONE
    } t_state;

    // One flag for each factor pointer (2, 3, 5)
    typedef struct packed {
        logic step_2;
        logic step_3;
        logic step_5;
    } t_adv;

endpackage

[rtl/core/hamming_number_generator_unit.sv]
// Top level of the Hamming number generator.
// Builds the 5-smooth sequence in a local memory; uses hng_pkg and hng_select.
//
//   channel  | valid    | ready    | payload
//   ---------+----------+----------+-----------------------------
//   request  | i_valid  | o_ready  | i_position (12 b, one-based)
//   result   | o_valid  | i_ready  | o_hamming_value (VALUE_WIDTH b)
//
// A request for position n runs n-1 steps. Each step writes the new entry,
// then refills the value of each advanced pointer, one at a time, through the
// single memory read port, then waits for the last read data to land. Steps
// near the top mostly advance two or three pointers.
// One request is worked at a time; a new one is taken while the last result
// waits in the output register. Reset clears control state only; the
// sequence memory needs no clearing since every entry is written before read.
module hamming_number_generator_unit #(
    parameter int MAX_N       = 2048,
    parameter int VALUE_WIDTH = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hng_pkg::POS_W-1:0]   i_position,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [VALUE_WIDTH-1:0]      o_hamming_value
);
    import hng_pkg::*;

    localparam int ADDR_W = $clog2(MAX_N);
    localparam int CNT_W  = $clog2(MAX_N + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [VALUE_WIDTH-1:0] mem [MAX_N];

    t_state                 r_state;
    t_state                 n_state;
    logic [CNT_W-1:0]       r_target;
    logic [CNT_W-1:0]       r_fill;
    logic [ADDR_W-1:0]      r_p2;
    logic [ADDR_W-1:0]      r_p3;
    logic [ADDR_W-1:0]      r_p5;
    logic [VALUE_WIDTH-1:0] r_v2;
    logic [VALUE_WIDTH-1:0] r_v3;
    logic [VALUE_WIDTH-1:0] r_v5;
    t_adv                   r_pend;
    t_adv                   r_rd_sel;
    logic                   r_rd_vld;
    logic [VALUE_WIDTH-1:0] r_rdata;
    logic [VALUE_WIDTH-1:0] r_result;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic                   r_out_valid;

    logic [CMP_W-1:0]       pos_ext;
    logic [CNT_W-1:0]       sat_n;
    logic [CNT_W-1:0]       fill_inc;
    logic [VALUE_WIDTH-1:0] best;
    t_adv                   adv;
    t_adv                   issue;
    logic                   wr_en;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;

    hng_select #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_select (
        .i_v2   (r_v2),
        .i_v3   (r_v3),
        .i_v5   (r_v5),
        .o_best (best),
        .o_adv  (adv)
    );

    // Clamp the requested position to 1..MAX_N
    assign pos_ext = CMP_W'(i_position);
    always_comb begin
        if (pos_ext == '0) begin
            sat_n = CNT_W'(1);
        end else if (pos_ext > CMP_W'(MAX_N)) begin
            sat_n = CNT_W'(MAX_N);
        end else begin
            sat_n = pos_ext[CNT_W-1:0];
        end
    end

    assign fill_inc        = r_fill + CNT_W'(1);
    assign o_valid         = r_out_valid;
    assign o_hamming_value = r_out_value;

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = r_p2;
        issue   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = (sat_n == CNT_W'(1)) ? S_DONE : S_STEP;
                end
            end
            S_STEP: begin
                wr_en   = 1'b1;
                n_state = (fill_inc == r_target) ? S_DONE : S_FETCH;
            end
            S_FETCH: begin
                // Refill one advanced pointer per cycle, lowest factor first
                if (r_pend.step_2) begin
                    rd_en        = 1'b1;
                    rd_addr      = r_p2;
                    issue.step_2 = 1'b1;
                end else if (r_pend.step_3) begin
                    rd_en        = 1'b1;
                    rd_addr      = r_p3;
                    issue.step_3 = 1'b1;
                end else if (r_pend.step_5) begin
                    rd_en        = 1'b1;
                    rd_addr      = r_p5;
                    issue.step_5 = 1'b1;
                end else begin
                    // last read data lands in its register at this edge
                    n_state = S_STEP;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_fill[ADDR_W-1:0]] <= best;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_pend      <= '0;
            r_rd_sel    <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            r_rd_sel <= issue;
            // The done state reloads the output register itself
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (r_rd_vld) begin
                if (r_rd_sel.step_2) begin
                    r_v2 <= r_rdata;
                end
                if (r_rd_sel.step_3) begin
                    r_v3 <= r_rdata;
                end
                if (r_rd_sel.step_5) begin
                    r_v5 <= r_rdata;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_target <= sat_n;
                        r_fill   <= CNT_W'(1);
                        r_p2     <= '0;
                        r_p3     <= '0;
                        r_p5     <= '0;
                        r_v2     <= VALUE_WIDTH'(1);
                        r_v3     <= VALUE_WIDTH'(1);
                        r_v5     <= VALUE_WIDTH'(1);
                        r_result <= VALUE_WIDTH'(1);
                    end
                end
                S_STEP: begin
                    r_fill   <= fill_inc;
                    r_result <= best;
                    r_p2     <= r_p2 + ADDR_W'(adv.step_2);
                    r_p3     <= r_p3 + ADDR_W'(adv.step_3);
                    r_p5     <= r_p5 + ADDR_W'(adv.step_5);
                    r_pend   <= adv;
                end
                S_FETCH: begin
                    if (issue.step_2) begin
                        r_pend.step_2 <= 1'b0;
                    end
                    if (issue.step_3) begin
                        r_pend.step_3 <= 1'b0;
                    end
                    if (issue.step_5) begin
                        r_pend.step_5 <= 1'b0;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_result;
                    end
                end
                default: begin
                    r_pend <= '0;
                end
            endcase
        end
    end

    // Pointer values must be settled before a step uses them
    a_no_read_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STEP |-> !r_rd_vld)
        else $error("read data still in flight at step");

    // Every pointer trails the fill count
    a_ptr_behind_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STEP |-> (CNT_W'(r_p2) < r_fill) && (CNT_W'(r_p3) < r_fill)
                              && (CNT_W'(r_p5) < r_fill))
        else $error("pointer reached fill count");

    // A step always advances at least one pointer
    a_step_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STEP |-> (adv.step_2 || adv.step_3 || adv.step_5))
        else $error("step advanced no pointer");

    // A result appears only from the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside done state");

endmodule

[rtl/core/hng_select.sv]
// Candidate former and minimum selector for the Hamming sequence.
// Forms saturated 2x, 3x and 5x products and picks the smallest.
// Depends on hng_pkg.
module hng_select #(
    parameter int VALUE_WIDTH = 40
) (
    input  logic [VALUE_WIDTH-1:0] i_v2,
    input  logic [VALUE_WIDTH-1:0] i_v3,
    input  logic [VALUE_WIDTH-1:0] i_v5,
    output logic [VALUE_WIDTH-1:0] o_best,
    output hng_pkg::t_adv          o_adv
);
    import hng_pkg::*;

    logic [VALUE_WIDTH:0]   w2;
    logic [VALUE_WIDTH+1:0] w3;
    logic [VALUE_WIDTH+2:0] w5;
    logic [VALUE_WIDTH-1:0] c2;
    logic [VALUE_WIDTH-1:0] c3;
    logic [VALUE_WIDTH-1:0] c5;

    // Shift-add products; any carry past the top saturates to all ones
    assign w2 = {i_v2, 1'b0};
    assign w3 = {2'b00, i_v3} + {1'b0, i_v3, 1'b0};
    assign w5 = {3'b000, i_v5} + {1'b0, i_v5, 2'b00};

    assign c2 = w2[VALUE_WIDTH] ? '1 : w2[VALUE_WIDTH-1:0];
    assign c3 = (|w3[VALUE_WIDTH+1:VALUE_WIDTH]) ? '1 : w3[VALUE_WIDTH-1:0];
    assign c5 = (|w5[VALUE_WIDTH+2:VALUE_WIDTH]) ? '1 : w5[VALUE_WIDTH-1:0];

    always_comb begin
        o_best = c2;
        if (c3 < o_best) begin
            o_best = c3;
        end
        if (c5 < o_best) begin
            o_best = c5;
        end
        // Advance every pointer that matches, so duplicates are skipped
        o_adv.step_2 = (c2 == o_best);
        o_adv.step_3 = (c3 == o_best);
        o_adv.step_5 = (c5 == o_best);
    end

endmodule

[tb/hamming_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the Hamming number generator: watches both channels,
// predicts each value with a three-pointer build of its own and compares.
// Depends on hng_pkg for the position width.
module hamming_result_checker #(
    parameter int MAX_N       = 2048,
    parameter int VALUE_WIDTH = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_ready,
    input  logic [hng_pkg::POS_W-1:0]   i_req_position,
    input  logic                        i_rsp_valid,
    input  logic                        i_rsp_ready,
    input  logic [VALUE_WIDTH-1:0]      i_rsp_value,
    input  logic                        i_end_check,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_req_count,
    output int                          o_rsp_count
);

    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

    typedef struct {
        logic [hng_pkg::POS_W-1:0] position;
        logic [VALUE_WIDTH-1:0]    value;
    } t_expected;

    t_expected   expected_values[$];
    logic [63:0] smooth_seq [MAX_N];
    int          fails = 0;
    int          reqs = 0;
    int          rsps = 0;
    bit          leftovers_reported = 1'b0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fails++;
    endtask

    function automatic logic [63:0] times_sat(input logic [63:0] base,
                                              input logic [63:0] factor);
        if (base > VALUE_MASK / factor)
            return VALUE_MASK;
        return base * factor;
    endfunction

    // Rebuild the sequence from 1 for every request, as the block does
    function automatic logic [VALUE_WIDTH-1:0] nth_hamming(
        input logic [hng_pkg::POS_W-1:0] position
    );
        int unsigned target;
        int unsigned filled;
        int unsigned idx2;
        int unsigned idx3;
        int unsigned idx5;
        logic [63:0] by2;
        logic [63:0] by3;
        logic [63:0] by5;
        logic [63:0] least;
        target = position;
        if (target == 0)
            target = 1;
        if (target > MAX_N)
            target = MAX_N;
        smooth_seq[0] = 64'd1;
        filled = 1;
        idx2 = 0;
        idx3 = 0;
        idx5 = 0;
        while (filled < target) begin
            by2 = times_sat(smooth_seq[idx2], 64'd2);
            by3 = times_sat(smooth_seq[idx3], 64'd3);
            by5 = times_sat(smooth_seq[idx5], 64'd5);
            least = by2;
            if (by3 < least)
                least = by3;
            if (by5 < least)
                least = by5;
            smooth_seq[filled] = least;
            // advance every pointer that hit the minimum to skip duplicates
            if (by2 == least)
                idx2++;
            if (by3 == least)
                idx3++;
            if (by5 == least)
                idx5++;
            filled++;
        end
        return smooth_seq[filled - 1][VALUE_WIDTH-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_expected entry;
        if (i_rst_n) begin
            // results first: a result never belongs to a request of the same edge
            if (i_rsp_valid && i_rsp_ready) begin
                rsps++;
                if (expected_values.size() == 0) begin
                    report_mismatch($sformatf("result 0x%0h with no request pending",
                                              i_rsp_value));
                end else begin
                    entry = expected_values.pop_front();
                    if (i_rsp_value !== entry.value)
                        report_mismatch($sformatf("position %0d: got 0x%0h, want 0x%0h",
                                                  entry.position, i_rsp_value,
                                                  entry.value));
                end
            end
            if (i_req_valid && i_req_ready) begin
                reqs++;
                entry.position = i_req_position;
                entry.value    = nth_hamming(i_req_position);
                expected_values.push_back(entry);
            end
            if (i_end_check && !leftovers_reported) begin
                leftovers_reported = 1'b1;
                if (expected_values.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived, oldest for position %0d",
                                              expected_values.size(),
                                              expected_values[0].position));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_values.size();
        o_req_count  <= reqs;
        o_rsp_count  <= rsps;
    end

endmodule

[tb/hamming_number_generator_unit_tb.sv]
`timescale 1ns / 1ps
// Top of the Hamming number generator testbench: clock, reset, request and
// result stimulus in idling phases, watchdog and verdict.
// Depends on hng_pkg, hamming_number_generator_unit and hamming_result_checker.
module hamming_number_generator_unit_tb;

    localparam int MAX_N           = 2048;
    localparam int VALUE_WIDTH     = 40;
    localparam int POS_W           = hng_pkg::POS_W;
    localparam int IDLE_LIMIT      = 40000;
    localparam int DRAIN_CYCLES    = 4 * MAX_N + 16;
    localparam int ITEMS_PER_PHASE = 67;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        i_ready = 1'b0;
    logic [hng_pkg::POS_W-1:0]   i_position = '0;
    logic                        o_ready;
    logic                        o_valid;
    logic [VALUE_WIDTH-1:0]      o_hamming_value;
    logic                        end_check = 1'b0;

    int fail_count;
    int pending;
    int req_count;
    int rsp_count;
    int stall_pct = 0;
    int idle_cycles = 0;
    int max_position = 0;

    always #2 i_clk = ~i_clk;

    hamming_number_generator_unit #(
        .MAX_N       (MAX_N),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hamming_value (o_hamming_value)
    );

    hamming_result_checker #(
        .MAX_N       (MAX_N),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_req_position (i_position),
        .i_rsp_valid    (o_valid),
        .i_rsp_ready    (i_ready),
        .i_rsp_value    (o_hamming_value),
        .i_end_check    (end_check),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_req_count    (req_count),
        .o_rsp_count    (rsp_count)
    );

    // Result side: stall at the rate of the current phase
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Mostly short positions keep the run short; a few reach the top and beyond
    function automatic logic [hng_pkg::POS_W-1:0] random_position();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return POS_W'($urandom_range(1, 64));
        else if (pick < 92)
            return POS_W'($urandom_range(65, 700));
        else if (pick < 97)
            return POS_W'($urandom_range(701, MAX_N));
        return POS_W'($urandom_range(0, (1 << hng_pkg::POS_W) - 1));
    endfunction

    // Called at a rising edge; returns at the edge of the transfer
    task automatic send_position(input logic [hng_pkg::POS_W-1:0] position,
                                 input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_position <= position;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        if (int'(position) > max_position)
            max_position = int'(position);
    endtask

    // Hold the request side until every result has been taken
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [hng_pkg::POS_W-1:0] directed [22] = '{
            12'd1, 12'd0, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6, 12'd7, 12'd8,
            12'd9, 12'd10, 12'd11, 12'd12, 12'd15, 12'd16, 12'd1024,
            12'h555, 12'd2047, 12'd2048, 12'd2049, 12'hAAA, 12'hFFF
        };
        int send_idle [4] = '{0, 79, 0, 32};
        int rsp_stall [4] = '{0, 0, 79, 32};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k])
            send_position(directed[k], 0);
        wait_for_results();

        for (int ph = 0; ph < 4; ph++) begin
            stall_pct = rsp_stall[ph];
            repeat (ITEMS_PER_PHASE)
                send_position(random_position(), send_idle[ph]);
            wait_for_results();
        end

        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("Covered %0d requests and %0d results, positions 0 to %0d incl. saturation",
                 req_count, rsp_count, max_position);
        $display("Phases: back-to-back, sender gaps, receiver stalls, both, with drains");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/hng_pkg.sv
rtl/core/hng_select.sv
rtl/core/hamming_number_generator_unit.sv
tb/hamming_result_checker.sv
tb/hamming_number_generator_unit_tb.sv
